// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions on clk / rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/sdx_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdx_pkg
// Shared types, codes and the letter classifier of the soundex encoder.
// ---------------------------------------------------------------------------
package sdx_pkg;

  typedef logic [7:0] char_t;
  typedef logic [2:0] code_t;

  localparam code_t CODE_NONE   = 3'd0;
  localparam code_t CODE_LABIAL = 3'd1;  // B F P V
  localparam code_t CODE_GUTTER = 3'd2;  // C G J K Q S X Z
  localparam code_t CODE_DENTAL = 3'd3;  // D T
  localparam code_t CODE_L      = 3'd4;
  localparam code_t CODE_NASAL  = 3'd5;  // M N
  localparam code_t CODE_R      = 3'd6;

  localparam int unsigned NUM_DIGITS = 3;

  // Classified letter, as held in the queue.
  typedef struct packed {
    char_t letter;
    code_t code;
    logic  last;
  } sdx_item_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } sdx_qstat_t;

  function automatic code_t letter_code(input char_t ch);
    code_t code;
    unique case (ch) inside
      "B", "F", "P", "V":                code = CODE_LABIAL;
      "C", "G", "J", "K", "Q", "S", "X", "Z": code = CODE_GUTTER;
      "D", "T":                          code = CODE_DENTAL;
      "L":                               code = CODE_L;
      "M", "N":                          code = CODE_NASAL;
      "R":                               code = CODE_R;
      default:                           code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

// File: hw/rtl/sdx_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdx_front
// Input stage: takes letters, classifies them and registers the result.
// ---------------------------------------------------------------------------
module sdx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] letter
  input  logic              in_tlast,   // last_letter
  output logic              item_valid,
  input  logic              item_ready,
  output sdx_pkg::sdx_item_t item
);
  import sdx_pkg::*;

  logic      valid_r, valid_nxt;
  sdx_item_t item_r, item_nxt;
  logic      in_xfer, out_xfer;

  assign out_xfer  = valid_r && item_ready;
  assign in_tready = !valid_r || item_ready;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (out_xfer) begin
      valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      valid_nxt       = 1'b1;
      item_nxt.letter = in_tdata;
      item_nxt.code   = letter_code(in_tdata);
      item_nxt.last   = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: hw/rtl/sdx_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdx_fifo
// Small queue of classified letters between the front and back stages.
// ---------------------------------------------------------------------------
module sdx_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  sdx_pkg::sdx_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output sdx_pkg::sdx_item_t rd_item,
  output sdx_pkg::sdx_qstat_t stat
);
  import sdx_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sdx_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);
  assign wr_ready   = !stat.full;
  assign rd_valid   = !stat.empty;
  assign rd_item    = mem_r[rd_ptr_r];
  assign push       = wr_valid && wr_ready;
  assign pop        = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: hw/rtl/sdx_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdx_back
// Code accumulator: builds the digits of a name and holds the result register.
// ---------------------------------------------------------------------------
module sdx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  sdx_pkg::sdx_item_t item,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata
);
  import sdx_pkg::*;

  logic       in_name_r, in_name_nxt;
  char_t      lead_r, lead_nxt;
  code_t      prev_r, prev_nxt;
  logic [1:0] kept_r, kept_nxt;
  code_t      digits_r [NUM_DIGITS];
  code_t      digits_nxt [NUM_DIGITS];
  logic       ovalid_r, ovalid_nxt;
  logic [23:0] odata_r, odata_nxt;
  logic       slot_free, pop;

  // The result slot is free if empty or being drained this cycle.
  assign slot_free  = !ovalid_r || out_tready;
  assign item_ready = !item.last || slot_free;
  assign pop        = item_valid && item_ready;

  always_comb begin
    in_name_nxt = in_name_r;
    lead_nxt    = lead_r;
    prev_nxt    = prev_r;
    kept_nxt    = kept_r;
    digits_nxt  = digits_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    odata_nxt   = odata_r;
    if (pop) begin
      if (!in_name_r) begin
        lead_nxt    = item.letter;
        kept_nxt    = '0;
        digits_nxt  = '{default: CODE_NONE};
        in_name_nxt = 1'b1;
      end else if (item.code != CODE_NONE && item.code != prev_r &&
                   kept_r != 2'(NUM_DIGITS)) begin
        digits_nxt[kept_r] = item.code;
        kept_nxt           = kept_r + 1'b1;
      end
      prev_nxt = item.code;
      if (item.last) begin
        in_name_nxt = 1'b0;
        ovalid_nxt  = 1'b1;
        odata_nxt   = {7'd0, digits_nxt[2], digits_nxt[1], digits_nxt[0], lead_nxt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_name_r <= 1'b0;
      lead_r    <= '0;
      prev_r    <= CODE_NONE;
      kept_r    <= '0;
      digits_r  <= '{default: CODE_NONE};
      ovalid_r  <= 1'b0;
    end else begin
      in_name_r <= in_name_nxt;
      lead_r    <= lead_nxt;
      prev_r    <= prev_nxt;
      kept_r    <= kept_nxt;
      digits_r  <= digits_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

// File: hw/rtl/soundex_encoder_top.sv
`timescale 1ns / 1ps
// Soundex encoder: one letter per transfer in, one four-symbol code out per name.
//
// Input stream: in_tdata[7:0] carries one ASCII letter, in_tlast marks the last
// letter of a name. The first letter of a name is kept as is; later letters are
// mapped to codes 1..6 (0 for anything else); adjacent repeats collapse, any
// code-0 letter (H and W too) splits a repeat, and at most three digits are kept.
// Output stream: one transfer per name, issued for the letter flagged by tlast:
// out_tdata[7:0] first character, [10:8] digit one, [13:11] digit two,
// [16:14] digit three, rest zero. Missing digits read as 0.
// Path to a result: the front register loads at the last letter's transfer, the
// queue stores the letter, and the back stage pops it and loads the result
// register at the same edge.
// Throughput: one letter per cycle while results are taken; the back stage
// takes one queued letter per cycle unless a last letter awaits the result slot.
// When the receiver stalls, the result register holds; letters keep flowing
// into the back stage until a further last letter needs the busy register,
// then the queue (QUEUE_DEPTH entries) and the front register fill and
// in_tready drops. Synchronous reset (rst_n low) empties all stages and
// starts waiting for the first letter of a new name.
// ---------------------------------------------------------------------------
// soundex_encoder_top
// Top level: front classifier, letter queue and code accumulator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module soundex_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] letter
  input  logic        in_tlast,    // last_letter
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // [7:0] first_char, [10:8] digit_one,
                                   // [13:11] digit_two, [16:14] digit_three
);
  import sdx_pkg::*;

  // front -> queue
  logic       f_valid, f_ready;
  sdx_item_t  f_item;
  // queue -> back
  logic       q_valid, q_ready;
  sdx_item_t  q_item;
  sdx_qstat_t q_stat;

  sdx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  sdx_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item),
    .stat     (q_stat)
  );

  sdx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Queue occupancy flags are mutually exclusive.
  `ASSERT_CLK(a_qstat_excl, !(q_stat.full && q_stat.empty), "queue full and empty")

  // A new result only follows a last letter taken from the queue.
  `ASSERT_CLK(a_res_src, $rose(out_tvalid) |-> $past(q_valid && q_ready && q_item.last),
    "result without a last letter")

  // Digits fill in order: a later digit implies the earlier ones.
  `ASSERT_CLK(a_dig_order,
    out_tvalid |-> ((out_tdata[13:11] == CODE_NONE || out_tdata[10:8] != CODE_NONE) &&
                    (out_tdata[16:14] == CODE_NONE || out_tdata[13:11] != CODE_NONE)),
    "digit gap in result")

  // No result right out of reset.
  `ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

// File: sim/soundex_encoder_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// soundex_encoder_top_test
// Self-checking bench for the soundex encoder. A short directed table covers
// single-letter names, byte extremes, every code class, repeats split by a
// vowel and names with more than three digits. Random names follow. Every
// accepted letter goes through a local soundex tracker that queues the code
// expected for each name, and each output transfer is checked against it.
// ---------------------------------------------------------------------------
module soundex_encoder_top_test;
  import sdx_pkg::*;

  localparam int unsigned RANDOM_LETTERS = 850;
  localparam int unsigned RX_HOLD_CYCLES = 300;  // long output back-pressure
  localparam int unsigned HOLD_AT        = 200;  // letter count that starts it
  localparam int unsigned PAUSE_AT       = 600;  // sender drains the block here
  localparam int unsigned QUIET_FROM     = 400;  // no idling on either side
  localparam int unsigned QUIET_TO       = 560;
  localparam int unsigned DRAIN_CYCLES   = 20;

  // One four-symbol soundex code.
  typedef struct packed {
    char_t first_char;
    code_t digit_one;
    code_t digit_two;
    code_t digit_three;
  } soundex_code_t;

  // Directed stimulus row: when known is set, want is the code for the name.
  typedef struct {
    char_t         letter;
    logic          last;
    logic          known;
    soundex_code_t want;
  } letter_row_t;

  localparam soundex_code_t NO_CODE = '{8'h00, CODE_NONE, CODE_NONE, CODE_NONE};
  localparam int unsigned DIRECTED_ROWS = 22;

  letter_row_t directed_rows [DIRECTED_ROWS] = '{
    // single-letter names, byte extremes included
    '{"A",   1'b1, 1'b1, '{"A",   CODE_NONE, CODE_NONE, CODE_NONE}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, CODE_NONE, CODE_NONE, CODE_NONE}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, CODE_NONE, CODE_NONE, CODE_NONE}},
    // vowel between equal codes: second B counts again
    '{"B", 1'b0, 1'b0, NO_CODE},
    '{"A", 1'b0, 1'b0, NO_CODE},
    '{"B", 1'b1, 1'b0, NO_CODE},
    // R O B E R T
    '{"R", 1'b0, 1'b0, NO_CODE},
    '{"O", 1'b0, 1'b0, NO_CODE},
    '{"B", 1'b0, 1'b0, NO_CODE},
    '{"E", 1'b0, 1'b0, NO_CODE},
    '{"R", 1'b0, 1'b0, NO_CODE},
    '{"T", 1'b1, 1'b0, NO_CODE},
    // four digits offered, only three kept
    '{"L", 1'b0, 1'b0, NO_CODE},
    '{"M", 1'b0, 1'b0, NO_CODE},
    '{"D", 1'b0, 1'b0, NO_CODE},
    '{"G", 1'b0, 1'b0, NO_CODE},
    '{"V", 1'b1, 1'b0, NO_CODE},
    // adjacent equal codes collapse
    '{"A", 1'b0, 1'b0, NO_CODE},
    '{"L", 1'b0, 1'b0, NO_CODE},
    '{"L", 1'b1, 1'b0, NO_CODE},
    // lower case: first kept verbatim, rest maps to zero
    '{"a", 1'b0, 1'b0, NO_CODE},
    '{"b", 1'b1, 1'b1, '{"a", CODE_NONE, CODE_NONE, CODE_NONE}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] letter
  logic        in_tlast;    // last_letter
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [7:0] first_char, [10:8] digit_one,
                            // [13:11] digit_two, [16:14] digit_three

  soundex_code_t expected_codes [$];
  int unsigned   mismatches   = 0;
  int unsigned   letters_sent = 0;
  bit            rx_hold_req  = 1'b0;

  // Soundex tracker state
  logic        name_open   = 1'b0;
  char_t       name_lead   = 8'h00;
  code_t       prior_code  = CODE_NONE;
  int unsigned kept_cnt    = 0;
  code_t       kept_digits [NUM_DIGITS] = '{CODE_NONE, CODE_NONE, CODE_NONE};

  soundex_encoder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Run limit, far beyond the slowest passing run.
  initial begin
    #2_000_000;
    $display("soundex_encoder_top_test failed");
    $finish;
  end

  function automatic code_t letter_class(input char_t ch);
    case (ch)
      "B", "F", "P", "V":                     return CODE_LABIAL;
      "C", "G", "J", "K", "Q", "S", "X", "Z": return CODE_GUTTER;
      "D", "T":                               return CODE_DENTAL;
      "L":                                    return CODE_L;
      "M", "N":                               return CODE_NASAL;
      "R":                                    return CODE_R;
      default:                                return CODE_NONE;
    endcase
  endfunction

  // Advance the tracker by one letter; returns 1 when the name completes.
  function automatic logic soundex_feed(input char_t ch, input logic last,
                                        output soundex_code_t code);
    code_t c;
    c = letter_class(ch);
    if (!name_open) begin
      name_lead   = ch;
      kept_cnt    = 0;
      kept_digits = '{CODE_NONE, CODE_NONE, CODE_NONE};
      name_open   = 1'b1;
    end else if (c != CODE_NONE && c != prior_code && kept_cnt < NUM_DIGITS) begin
      kept_digits[kept_cnt] = c;
      kept_cnt++;
    end
    prior_code = c;
    code = '{name_lead, kept_digits[0], kept_digits[1], kept_digits[2]};
    if (last)
      name_open = 1'b0;
    return last;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_code(input logic [23:0] word);
    soundex_code_t want;
    if (expected_codes.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, word);
      mismatches++;
      return;
    end
    want = expected_codes.pop_front();
    compare_field("first_char",  want.first_char,  word[7:0]);
    compare_field("digit_one",   want.digit_one,   word[10:8]);
    compare_field("digit_two",   want.digit_two,   word[13:11]);
    compare_field("digit_three", want.digit_three, word[16:14]);
    compare_field("padding",     0,                word[23:17]);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_code(out_tdata);
  end

  function automatic bit quiet_window();
    return letters_sent >= QUIET_FROM && letters_sent < QUIET_TO;
  endfunction

  // Receiver: random stalls, plus one long hold-off requested by the sender.
  initial begin
    int unsigned held;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        for (held = 0; held < RX_HOLD_CYCLES; held++)
          @(posedge clk);
        rx_hold_req = 1'b0;
      end
      out_tready <= quiet_window() || $urandom_range(99) >= 8;
    end
  end

  // One letter transfer; the tracker runs on acceptance.
  task automatic offer_letter(input char_t ch, input logic last, input logic known,
                              input soundex_code_t want);
    soundex_code_t code;
    if (!quiet_window() && $urandom_range(99) < 4) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (soundex_feed(ch, last, code))
      expected_codes.insert(expected_codes.size(), known ? want : code);
    letters_sent++;
    // output side goes quiet while letters keep coming, so the block backs up
    if (letters_sent == HOLD_AT)
      rx_hold_req = 1'b1;
  endtask

  // Random name: mostly upper case with repeats, some arbitrary bytes.
  task automatic offer_random_name();
    int unsigned len;
    int unsigned i;
    int unsigned pick;
    char_t       ch;
    len = ($urandom_range(99) < 6) ? $urandom_range(40, 12) : $urandom_range(9, 1);
    ch  = "A";
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (i == 0 || pick >= 15)
        ch = (pick < 30) ? char_t'($urandom_range(255)) : char_t'($urandom_range("Z", "A"));
      offer_letter(ch, i == len - 1, 1'b0, NO_CODE);
    end
  endtask

  // Sender: directed table, then random names, then drain and verdict.
  initial begin
    int unsigned row;
    bit          paused;
    paused    = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tlast  <= 1'b0;
    do @(posedge clk); while (!rst_n);

    for (row = 0; row < DIRECTED_ROWS; row++)
      offer_letter(directed_rows[row].letter, directed_rows[row].last,
                   directed_rows[row].known, directed_rows[row].want);

    while (letters_sent < DIRECTED_ROWS + RANDOM_LETTERS) begin
      // once, let the block drain completely between names
      if (!paused && letters_sent >= PAUSE_AT) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (expected_codes.size() != 0);
      end
      offer_random_name();
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_codes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("soundex_encoder_top_test passed");
    else
      $display("soundex_encoder_top_test failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sdx_pkg.sv
hw/rtl/sdx_front.sv
hw/rtl/sdx_fifo.sv
hw/rtl/sdx_back.sv
hw/rtl/soundex_encoder_top.sv
sim/soundex_encoder_top_test.sv
